@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the sonar theremin controller
// Widths, register indexes, event codes, controller states and the command
// and status words that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  // Fraction bits of the distance values (4 to 12)
  localparam int FRACTION_BITS = 8;

  // Field widths
  localparam int ECHO_W     = 14;
  localparam int FREQ_W     = 16;
  localparam int VOL_W      = 15;
  localparam int KIND_W     = 2;
  localparam int ALPHA_W    = 9;
  localparam int DIST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Echo time in us times 17 gives distance in cm times 1000
  localparam int SPEED_FACTOR = 17;
  localparam int SCALED_W     = 19;
  localparam int CM_SCALE     = 1000;
  localparam int CM_HALF      = CM_SCALE / 2;

  // Divide by 1000 as an exact shift by 3 and a multiply by the reciprocal
  // of 125; the shift keeps the quotient exact because the reciprocal's
  // rounding excess (below 128) times the operand stays under 2^RECIP_SHIFT
  localparam int     CM_PRE_SHIFT = 3;
  localparam int     CM_ODD       = CM_SCALE >> CM_PRE_SHIFT;
  localparam int     DPRE_W       = SCALED_W + FRACTION_BITS - CM_PRE_SHIFT + 1;
  localparam int     RECIP_SHIFT  = DPRE_W + 7;
  localparam int     RECIP_W      = RECIP_SHIFT - 6;
  localparam longint RECIP_VAL    = ((longint'(1) << RECIP_SHIFT) + CM_ODD - 1) / CM_ODD;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_VAL);
  localparam int     DPROD_W      = DPRE_W + RECIP_W;

  // Filter weight in Q1.8
  localparam int ALPHA_FRAC = 8;
  localparam int ALPHA_ONE  = 1 << ALPHA_FRAC;
  localparam int ALPHA_HALF = ALPHA_ONE / 2;

  // Derived datapath widths
  localparam int FD_W   = DIST_W + FRACTION_BITS;   // filtered distance
  localparam int DEN_W  = DIST_W + FRACTION_BITS;   // cutoff in fixed point
  localparam int PROD_W = ALPHA_W + FD_W;           // filter product
  localparam int ACC_W  = PROD_W + 1;               // filter sum
  localparam int MAG_W  = FREQ_W + FD_W;            // pitch product
  localparam int DIV_W  = MAG_W + 1;                // divider dividend
  localparam int DVS_W  = DEN_W;                    // divider divisor
  localparam int CNT_W  = $clog2(DIV_W + 1);

  // Reset values of the configuration registers
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(77);
  localparam logic [DIST_W-1:0]  CUTOFF_RESET = DIST_W'(40);
  localparam logic [DIST_W-1:0]  PRESS_RESET  = DIST_W'(20);
  localparam logic [DIST_W-1:0]  MAX_RESET    = DIST_W'(220);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 2'd0,
    REG_CUTOFF = 2'd1,
    REG_PRESS  = 2'd2,
    REG_MAX    = 2'd3
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 2'd0,
    EV_UPDATE  = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FILT_MUL,
    ST_FILT_ACC,
    ST_DECIDE,
    ST_PITCH_MUL,
    ST_PITCH_GO,
    ST_DIV_PITCH,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic        load_in;
    logic        div_start;
    logic        d_load;
    logic        filt_mul;
    logic        filt_acc;
    logic        pitch_mul;
    logic        pitch_load;
    logic        out_load;
    event_kind_e out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic press;
    logic over_cut;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/stc_divider.sv @@
// ----------------------------------------------------------------------------
// stc_divider: restoring divider, one quotient bit per cycle
// Takes a dividend and divisor on start, pulses done when the quotient is
// ready. Serves the pitch interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [stc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [stc_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [stc_pkg::DIV_W-1:0]  quotient_o
);
  import stc_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], fits};
  end

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands on start, step while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CNT_W'(1)) |=> (done_q && !busy_q))
    else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

@@ rtl/stc_datapath.sv @@
// ----------------------------------------------------------------------------
// stc_datapath: arithmetic and storage of the sonar theremin controller
// Holds the configuration registers, the captured input word, the filtered
// distance and the output word; converts echo time, filters and
// interpolates the pitch under command of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [stc_pkg::ECHO_W-1:0]      echo_time_i,
  input  logic [stc_pkg::FREQ_W-1:0]      low_frequency_i,
  input  logic [stc_pkg::FREQ_W-1:0]      high_frequency_i,
  input  logic [stc_pkg::VOL_W-1:0]       note_volume_i,
  input  stc_pkg::dp_cmd_t                cmd_i,
  output stc_pkg::dp_status_t             status_o,
  output logic [stc_pkg::KIND_W-1:0]      event_kind_o,
  output logic [stc_pkg::FREQ_W-1:0]      frequency_o,
  output logic [stc_pkg::VOL_W-1:0]       amplitude_o
);
  import stc_pkg::*;

  // Configuration registers
  logic [ALPHA_W-1:0] alpha_q;
  logic [DIST_W-1:0]  cutoff_q;
  logic [DIST_W-1:0]  press_q;
  logic [DIST_W-1:0]  max_q;

  // Captured input word
  logic [SCALED_W-1:0] scaled_q;
  logic [FREQ_W-1:0]   lo_q;
  logic [FREQ_W-1:0]   hi_q;
  logic [VOL_W-1:0]    vol_q;

  // Working registers
  logic [FD_W-1:0]   f_q;
  logic [FD_W-1:0]   d_q;
  logic [PROD_W-1:0] prod_q;
  logic [MAG_W-1:0]  mag_q;
  logic              neg_q;
  logic [FREQ_W-1:0] pitch_q;

  // Output word
  event_kind_e       kind_q;
  logic [FREQ_W-1:0] freq_q;
  logic [VOL_W-1:0]  amp_q;

  logic [ALPHA_W-1:0]  alpha_eff;
  logic [ALPHA_W-1:0]  alpha_rest;
  logic [DIST_W-1:0]   cut_eff;
  logic [DEN_W-1:0]    den;
  logic [SCALED_W-1:0] scaled_d;
  logic [SCALED_W-1:0] max_scaled;
  logic [SCALED_W-1:0] press_scaled;
  logic [DPRE_W-1:0]   d_pre;
  logic [DPROD_W-1:0]  d_prod;
  logic [ACC_W-1:0]    acc;
  logic [FREQ_W-1:0]   span;
  logic [DIV_W-1:0]    dividend;
  logic [DVS_W-1:0]    divisor;
  logic                div_done;
  logic [DIV_W-1:0]    quotient;
  logic [DIV_W:0]      up_sum;
  logic [FREQ_W-1:0]   pitch_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      cutoff_q <= CUTOFF_RESET;
      press_q  <= PRESS_RESET;
      max_q    <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ALPHA:  alpha_q  <= cfg_data_i;
        REG_CUTOFF: cutoff_q <= cfg_data_i[DIST_W-1:0];
        REG_PRESS:  press_q  <= cfg_data_i[DIST_W-1:0];
        REG_MAX:    max_q    <= cfg_data_i[DIST_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp alpha to one, lift a zero cutoff to one
  always_comb begin
    alpha_eff  = (alpha_q > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_q;
    alpha_rest = ALPHA_W'(ALPHA_ONE) - alpha_eff;
    cut_eff    = (cutoff_q == '0) ? DIST_W'(1) : cutoff_q;
    den        = {cut_eff, {FRACTION_BITS{1'b0}}};
  end

  // Echo time times 17 is distance in cm times 1000
  assign scaled_d     = {1'b0, echo_time_i, 4'b0000} + SCALED_W'(echo_time_i);
  assign max_scaled   = SCALED_W'(max_q) * SCALED_W'(CM_SCALE);
  assign press_scaled = SCALED_W'(press_q) * SCALED_W'(CM_SCALE);

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      scaled_q <= scaled_d;
      lo_q     <= low_frequency_i;
      hi_q     <= high_frequency_i;
      vol_q    <= note_volume_i;
    end
  end

  // Rounded distance: take out the factor 8 of 1000 exactly, then multiply
  // by the reciprocal of 125
  assign d_pre  = DPRE_W'({scaled_q, {(FRACTION_BITS - CM_PRE_SHIFT){1'b0}}})
                + DPRE_W'(CM_HALF >> CM_PRE_SHIFT);
  assign d_prod = DPROD_W'(d_pre) * DPROD_W'(RECIP_MUL);

  // Feed the pitch divider
  assign dividend = DIV_W'(mag_q) + DIV_W'(den >> 1);
  assign divisor  = den;

  stc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Filter sum and pitch span
  always_comb begin
    acc  = ACC_W'(prod_q) + ACC_W'(alpha_eff) * ACC_W'(d_q) + ACC_W'(ALPHA_HALF);
    span = (lo_q > hi_q) ? (lo_q - hi_q) : (hi_q - lo_q);
  end

  // Apply the signed step to the low pitch and clamp to the pitch range
  always_comb begin
    up_sum = (DIV_W + 1)'(lo_q) + (DIV_W + 1)'(quotient);
    if (neg_q) begin
      pitch_d = (quotient > DIV_W'(lo_q)) ? '0 : (lo_q - quotient[FREQ_W-1:0]);
    end else begin
      pitch_d = (up_sum > (DIV_W + 1)'({FREQ_W{1'b1}})) ? {FREQ_W{1'b1}}
                                                          : up_sum[FREQ_W-1:0];
    end
  end

  // Filtered distance is state: clear on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (cmd_i.filt_acc) begin
      f_q <= acc[FD_W+ALPHA_FRAC-1:ALPHA_FRAC];
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.d_load) begin
      d_q <= d_prod[RECIP_SHIFT +: FD_W];
    end
    if (cmd_i.filt_mul) begin
      prod_q <= PROD_W'(alpha_rest) * PROD_W'(f_q);
    end
    if (cmd_i.pitch_mul) begin
      mag_q <= MAG_W'(span) * MAG_W'(f_q);
      neg_q <= lo_q > hi_q;
    end
    if (cmd_i.pitch_load) begin
      pitch_q <= pitch_d;
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == EV_RELEASE) begin
        freq_q <= '0;
        amp_q  <= '0;
      end else begin
        freq_q <= pitch_q;
        amp_q  <= vol_q;
      end
    end
  end

  // Report decisions to the controller
  always_comb begin
    status_o.drop     = (scaled_q == '0) || (scaled_q > max_scaled);
    status_o.press    = scaled_q < press_scaled;
    status_o.over_cut = f_q > den;
    status_o.div_done = div_done;
  end

  assign event_kind_o = kind_q;
  assign frequency_o  = freq_q;
  assign amplitude_o  = amp_q;

endmodule

`default_nettype wire

@@ rtl/stc_ctrl.sv @@
// ----------------------------------------------------------------------------
// stc_ctrl: sequencing state machine of the sonar theremin controller
// Walks one word through drop check, distance conversion, filtering, the
// note decision and the pitch division, tracks the held note and the output
// register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  stc_pkg::dp_status_t  status_i,
  output stc_pkg::dp_cmd_t     cmd_o
);
  import stc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        note_active_q, note_active_d;
  logic        out_valid_q, out_valid_d;
  event_kind_e kind_q, kind_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    note_active_d = note_active_q;
    kind_d        = kind_q;
    cmd_o         = '0;
    cmd_o.out_kind = kind_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.drop) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.d_load = 1'b1;
          state_d      = ST_FILT_MUL;
        end
      end
      ST_FILT_MUL: begin
        cmd_o.filt_mul = 1'b1;
        state_d        = ST_FILT_ACC;
      end
      ST_FILT_ACC: begin
        cmd_o.filt_acc = 1'b1;
        state_d        = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (note_active_q && status_i.over_cut) begin
          note_active_d = 1'b0;
          kind_d        = EV_RELEASE;
          state_d       = ST_EMIT;
        end else if (!note_active_q) begin
          if (status_i.press) begin
            note_active_d = 1'b1;
            kind_d        = EV_PRESS;
            state_d       = ST_PITCH_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          kind_d  = EV_UPDATE;
          state_d = ST_PITCH_MUL;
        end
      end
      ST_PITCH_MUL: begin
        cmd_o.pitch_mul = 1'b1;
        state_d         = ST_PITCH_GO;
      end
      ST_PITCH_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_PITCH;
      end
      ST_DIV_PITCH: begin
        if (status_i.div_done) begin
          cmd_o.pitch_load = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      note_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      note_active_q <= note_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Event kind of the word in flight
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIV_PITCH))
    else $error("division finished while no division was awaited");

  a_note_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (note_active_q != $past(note_active_q)) |-> ($past(state_q) == ST_DECIDE))
    else $error("held note changed outside the note decision");
`endif

endmodule

`default_nettype wire

@@ rtl/sonar_theremin_controller_top.sv @@
// ----------------------------------------------------------------------------
// sonar_theremin_controller_top: echo time to note press, update and release
// Converts each echo time to a fixed-point distance, drops timeouts and far
// samples, low-pass filters the distance and drives one note from it.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                                  Handshake
//   --------  ---------  ---------------------------------------  ----------
//   in        input      echo_time, low/high_frequency, note_vol  valid/ready
//   out       output     event_kind, frequency, amplitude         valid/ready
//   cfg       input      cfg_we_i, cfg_index_i, cfg_data_i        write only
//
// A dropped word goes from the drop check back to idle. A press or update
// steps through filtering, the note decision, the pitch product, the
// one-bit-per-cycle pitch divider and the emit step to the output register;
// a release skips the pitch steps. A word with no event goes back to idle
// after the note decision. The next word is accepted while the output word
// waits; a full output register holds the controller in its emit step.
// Reset clears the filtered distance, the held note and the configuration
// to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_theremin_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [stc_pkg::ECHO_W-1:0]      echo_time_i,
  input  logic [stc_pkg::FREQ_W-1:0]      low_frequency_i,
  input  logic [stc_pkg::FREQ_W-1:0]      high_frequency_i,
  input  logic [stc_pkg::VOL_W-1:0]       note_volume_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stc_pkg::KIND_W-1:0]      event_kind_o,
  output logic [stc_pkg::FREQ_W-1:0]      frequency_o,
  output logic [stc_pkg::VOL_W-1:0]       amplitude_o
);
  import stc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence each word
  stc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Compute and hold values
  stc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .echo_time_i      (echo_time_i),
    .low_frequency_i  (low_frequency_i),
    .high_frequency_i (high_frequency_i),
    .note_volume_i    (note_volume_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .event_kind_o     (event_kind_o),
    .frequency_o      (frequency_o),
    .amplitude_o      (amplitude_o)
  );

endmodule

`default_nettype wire

@@ tb/note_event_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_event_checker: scoreboard for the sonar theremin controller
// Watches the configuration port and both word channels. Each accepted echo
// word runs through a local model of the distance filter and the note
// tracker. Each event word that leaves the block is compared field by field
// with the oldest predicted event.
// ----------------------------------------------------------------------------
module note_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [stc_pkg::ECHO_W-1:0]     echo_time_i,
  input  logic [stc_pkg::FREQ_W-1:0]     low_frequency_i,
  input  logic [stc_pkg::FREQ_W-1:0]     high_frequency_i,
  input  logic [stc_pkg::VOL_W-1:0]      note_volume_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [stc_pkg::KIND_W-1:0]     event_kind_i,
  input  logic [stc_pkg::FREQ_W-1:0]     frequency_i,
  input  logic [stc_pkg::VOL_W-1:0]      amplitude_i,
  output int                             error_count_o,
  output int                             pending_o
);
  import stc_pkg::*;

  localparam longint FREQ_MAX = (1 << FREQ_W) - 1;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    event_kind_e         kind;
    logic [FREQ_W-1:0]   freq;
    logic [VOL_W-1:0]    amp;
  } note_event_t;

  // Local copy of the settings and of the tracker state
  logic [ALPHA_W-1:0] alpha_q;
  logic [DIST_W-1:0]  cutoff_q;
  logic [DIST_W-1:0]  press_q;
  logic [DIST_W-1:0]  max_q;
  logic [FD_W-1:0]    filt_q;
  logic               held_q;

  note_event_t event_q[$];

  // Count each mismatch and print a line for the first PRINT_CAP of them
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (error_count_o < PRINT_CAP) begin
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
    error_count_o++;
  endtask

  // Pitch interpolated from low to high over the cutoff span, clamped
  function automatic logic [FREQ_W-1:0] interp_pitch(input logic [FREQ_W-1:0] lo,
                                                     input logic [FREQ_W-1:0] hi,
                                                     input longint span);
    longint diff, mag, den, quot, pitch;
    diff = longint'(hi) - longint'(lo);
    mag = (diff < 0 ? -diff : diff) * longint'(filt_q);
    den = span << FRACTION_BITS;
    quot = (mag + den / 2) / den;
    pitch = (diff < 0) ? longint'(lo) - quot : longint'(lo) + quot;
    if (pitch < 0) pitch = 0;
    if (pitch > FREQ_MAX) pitch = FREQ_MAX;
    return FREQ_W'(pitch);
  endfunction

  // Advance the filter and note state by one echo; return 1 with an event
  function automatic bit track_echo(input logic [ECHO_W-1:0] echo,
                                    input logic [FREQ_W-1:0] lo,
                                    input logic [FREQ_W-1:0] hi,
                                    input logic [VOL_W-1:0] vol,
                                    output note_event_t ev);
    longint scaled, raw_dist, acc, weight, span;
    scaled = longint'(echo) * SPEED_FACTOR;
    weight = (longint'(alpha_q) > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha_q);
    span = (cutoff_q == '0) ? 1 : longint'(cutoff_q);
    ev = '0;

    // Drop timeouts and far samples without touching the state
    if (echo == '0 || scaled > longint'(max_q) * CM_SCALE) return 1'b0;

    raw_dist = ((scaled << FRACTION_BITS) + CM_HALF) / CM_SCALE;
    acc = (ALPHA_ONE - weight) * longint'(filt_q) + weight * raw_dist + ALPHA_HALF;
    filt_q = FD_W'(acc >> ALPHA_FRAC);

    if (held_q && longint'(filt_q) > (span << FRACTION_BITS)) begin
      held_q = 1'b0;
      ev.kind = EV_RELEASE;
      return 1'b1;
    end

    if (!held_q) begin
      if (scaled < longint'(press_q) * CM_SCALE) begin
        held_q = 1'b1;
        ev.kind = EV_PRESS;
        ev.freq = interp_pitch(lo, hi, span);
        ev.amp = vol;
        return 1'b1;
      end
      return 1'b0;
    end

    ev.kind = EV_UPDATE;
    ev.freq = interp_pitch(lo, hi, span);
    ev.amp = vol;
    return 1'b1;
  endfunction

  // Track settings, predict on each echo word, compare each event word
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    note_event_t want;
    note_event_t ev;
    if (!rst_ni) begin
      alpha_q  = ALPHA_RESET;
      cutoff_q = CUTOFF_RESET;
      press_q  = PRESS_RESET;
      max_q    = MAX_RESET;
      filt_q   = '0;
      held_q   = 1'b0;
      event_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ALPHA:  alpha_q = cfg_data_i[ALPHA_W-1:0];
          REG_CUTOFF: cutoff_q = cfg_data_i[DIST_W-1:0];
          REG_PRESS:  press_q = cfg_data_i[DIST_W-1:0];
          REG_MAX:    max_q = cfg_data_i[DIST_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (event_q.size() == 0) begin
          flag_mismatch("unexpected event word, kind", event_kind_i, -1);
        end else begin
          want = event_q.pop_front();
          if (event_kind_i !== want.kind) flag_mismatch("event_kind", event_kind_i, want.kind);
          if (frequency_i !== want.freq) flag_mismatch("frequency", frequency_i, want.freq);
          if (amplitude_i !== want.amp) flag_mismatch("amplitude", amplitude_i, want.amp);
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (track_echo(echo_time_i, low_frequency_i, high_frequency_i, note_volume_i, ev)) begin
          event_q.push_back(ev);
        end
      end

      pending_o = event_q.size();
    end
  end

endmodule

@@ tb/sonar_theremin_controller_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sonar_theremin_controller_top_test: stimulus and verdict for the controller
// Drives a directed run of edge echoes and note transitions, then hand
// gestures (approach, hover, retreat) mixed with timeouts and far noise over
// several register settings, with random gaps and stalls on both channels.
// The event checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
module sonar_theremin_controller_top_test;
  import stc_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD     = 400;
  localparam int RUN_LIMIT_NS  = 6_000_000;
  localparam int ECHO_MAX      = (1 << ECHO_W) - 1;
  localparam int NUM_PHASES    = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ECHO_W-1:0]     echo_time_i = '0;
  logic [FREQ_W-1:0]     low_frequency_i = '0;
  logic [FREQ_W-1:0]     high_frequency_i = '0;
  logic [VOL_W-1:0]      note_volume_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [KIND_W-1:0]     event_kind_o;
  logic [FREQ_W-1:0]     frequency_o;
  logic [VOL_W-1:0]      amplitude_o;

  int fail_count;
  int pending_count;

  // Shared between the sender and the receiver
  bit no_idle = 1'b0;
  int hold_off_cycles = 0;

  // Current settings, used only to aim the gestures
  int cur_cut = CUTOFF_RESET;
  int cur_press = PRESS_RESET;
  int cur_max = MAX_RESET;
  int hand_zone = 0;

  sonar_theremin_controller_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .echo_time_i      (echo_time_i),
    .low_frequency_i  (low_frequency_i),
    .high_frequency_i (high_frequency_i),
    .note_volume_i    (note_volume_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .frequency_o      (frequency_o),
    .amplitude_o      (amplitude_o)
  );

  note_event_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .echo_time_i      (echo_time_i),
    .low_frequency_i  (low_frequency_i),
    .high_frequency_i (high_frequency_i),
    .note_volume_i    (note_volume_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_i     (event_kind_o),
    .frequency_i      (frequency_o),
    .amplitude_i      (amplitude_o),
    .error_count_o    (fail_count),
    .pending_o        (pending_count)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Event receiver: random stall before each word, long hold on request
  initial begin : drain
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one echo word after a random gap and hold it until accepted
  task automatic send_word(input logic [ECHO_W-1:0] echo, input logic [FREQ_W-1:0] lo,
                           input logic [FREQ_W-1:0] hi, input logic [VOL_W-1:0] vol);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    echo_time_i      <= echo;
    low_frequency_i  <= lo;
    high_frequency_i <= hi;
    note_volume_i    <= vol;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted event has come out
  task automatic drain_events();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Drain, then stay idle so the block can finish a word that yields no event
  task automatic settle();
    drain_events();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all four registers, block idle
  task automatic apply_settings(input logic [ALPHA_W-1:0] alpha, input logic [DIST_W-1:0] cut,
                                input logic [DIST_W-1:0] press, input logic [DIST_W-1:0] far);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ALPHA;
    cfg_data_i  <= CFG_DATA_W'(alpha);
    @(negedge clk_i);
    cfg_index_i <= REG_CUTOFF;
    cfg_data_i  <= CFG_DATA_W'(cut);
    @(negedge clk_i);
    cfg_index_i <= REG_PRESS;
    cfg_data_i  <= CFG_DATA_W'(press);
    @(negedge clk_i);
    cfg_index_i <= REG_MAX;
    cfg_data_i  <= CFG_DATA_W'(far);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cut = cut;
    cur_press = press;
    cur_max = far;
  endtask

  // Echo whose distance times 1000 lies in the given range, kept legal
  function automatic logic [ECHO_W-1:0] echo_between(input int lo_mcm, input int hi_mcm);
    int first, last;
    first = (lo_mcm + SPEED_FACTOR - 1) / SPEED_FACTOR;
    last = hi_mcm / SPEED_FACTOR;
    if (first < 1) first = 1;
    if (first > ECHO_MAX) first = ECHO_MAX;
    if (last > ECHO_MAX) last = ECHO_MAX;
    if (last < first) last = first;
    return ECHO_W'($urandom_range(last, first));
  endfunction

  // Hand moving near, hovering, pulling away; with timeouts and far noise
  function automatic logic [ECHO_W-1:0] gesture_echo();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 9) return ECHO_W'($urandom);
    if (pick < 14) return echo_between(cur_max * CM_SCALE + 1, ECHO_MAX * SPEED_FACTOR);
    if ($urandom_range(0, 4) == 0) hand_zone = (hand_zone + 1) % 3;
    case (hand_zone)
      0:       return echo_between(0, cur_press * CM_SCALE - 1);
      1:       return echo_between(cur_press * CM_SCALE, cur_cut * CM_SCALE);
      default: return echo_between(cur_cut * CM_SCALE, cur_max * CM_SCALE);
    endcase
  endfunction

  // Pitch bound: extremes now and then, random otherwise
  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    int phase, n, items, cut, press;
    logic [VOL_W-1:0] vol;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: drops at the edges, press, updates both ways, release
    send_word('0, 16'd1000, 16'd2000, 15'd100);
    send_word(ECHO_W'(ECHO_MAX), 16'd1000, 16'd2000, 15'd100);
    send_word(14'd12942, 16'd1000, 16'd2000, 15'd100);
    send_word(14'd1176, 16'd0, 16'hFFFF, 15'h7FFF);
    send_word(14'd1000, 16'hFFFF, 16'd0, 15'd0);
    send_word(14'd1, 16'hAAAA, 16'h5555, 15'h5555);
    // Pull away until the note releases, then stay idle without press
    repeat (8) send_word(14'd12941, 16'd500, 16'd800, 15'h2AAA);
    // Press while the smoothed distance is still past the cutoff: clamp high
    send_word(14'd1176, 16'd0, 16'hFFFF, 15'd1);
    send_word(14'd1176, 16'd300, 16'd600, 15'd2);
    // Same with falling pitch: clamp at zero
    send_word(14'd1175, 16'd100, 16'd0, 15'd3);
    send_word(14'd1175, 16'd100, 16'd0, 15'd4);
    // Hover close until the filter catches up
    repeat (6) send_word(14'd500, 16'd1234, 16'd4321, 15'd777);
    settle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: apply_settings(9'd256, 8'd255, 8'd255, 8'd255);
        2: apply_settings(9'd0, 8'd1, 8'd255, 8'd1);
        3: apply_settings(9'd511, 8'd0, 8'd0, 8'd0);
        4: apply_settings(9'd1, 8'd0, 8'd0, 8'd255);
        5, 6: begin
          cut = $urandom_range(10, 255);
          press = $urandom_range(5, cut);
          apply_settings(ALPHA_W'($urandom_range(0, 300)), DIST_W'(cut), DIST_W'(press),
                         DIST_W'($urandom_range(cut, 255)));
        end
        7: apply_settings(9'd128, 8'd60, 8'd30, 8'd200);
        default: ;
      endcase

      case (phase)
        0:       items = 300;
        1:       items = 250;
        2, 4:    items = 100;
        3:       items = 50;
        default: items = 200;
      endcase

      for (n = 0; n < items; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (phase == 0 && n == 100) hold_off_cycles = LONG_HOLD;
        if ((phase == 0 && n == 150) || $urandom_range(0, 59) == 0) drain_events();
        vol = ($urandom_range(0, 9) == 0) ? '1 : VOL_W'($urandom);
        send_word(gesture_echo(), pick_freq(), pick_freq(), vol);
      end
      settle();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/stc_pkg.sv
rtl/stc_divider.sv
rtl/stc_datapath.sv
rtl/stc_ctrl.sv
rtl/sonar_theremin_controller_top.sv
tb/note_event_checker.sv
tb/sonar_theremin_controller_top_test.sv
